>>> hw/rtl/jlgs_pkg.sv
// Shared types and constants of the Jacobi Laplace grid solver.
// Used by every module under hw/rtl but jlgs_grid_mem; depends on nothing.
package jlgs_pkg;

  localparam int GRID_MAX_DEF  = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int VAL_W   = 23;
  localparam int SWEEP_W = 16;
  localparam int GS_W    = 7;
  localparam int POS_W   = 6;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 40;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  localparam logic [GS_W-1:0]    GRID_SIZE_RST  = 7'd64;
  localparam logic [SWEEP_W-1:0] ITER_LIMIT_RST = 16'd5000;

  typedef enum logic [2:0] {
    REG_GRID_SIZE  = 3'd0,
    REG_TOLERANCE  = 3'd1,
    REG_ITER_LIMIT = 3'd2,
    REG_INIT_VALUE = 3'd3,
    REG_EDGE_TOP   = 3'd4,
    REG_EDGE_BOT   = 3'd5,
    REG_EDGE_LEFT  = 3'd6,
    REG_EDGE_RIGHT = 3'd7
  } reg_idx_t;

  typedef enum logic {
    ACT_SOLVE = 1'b0,
    ACT_READ  = 1'b1
  } action_t;

  typedef struct packed {
    logic [GS_W-1:0]    grid_size;
    logic [VAL_W-1:0]   tolerance;
    logic [SWEEP_W-1:0] iter_limit;
    logic [VAL_W-1:0]   init_value;
    logic [VAL_W-1:0]   edge_top;
    logic [VAL_W-1:0]   edge_bot;
    logic [VAL_W-1:0]   edge_left;
    logic [VAL_W-1:0]   edge_right;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic we_a;
    logic we_b;
  } mem_ctl_t;

  typedef struct packed {
    logic               done;
    logic               conv;
    logic [SWEEP_W-1:0] sweeps;
  } status_t;

endpackage

>>> hw/rtl/jlgs_cfg_regs.sv
// Configuration register file of the grid solver, APB-style write/read port.
// Depends on jlgs_pkg for the register map and the cfg_t bundle.
module jlgs_cfg_regs #(
  parameter int FRAC_BITS = jlgs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [jlgs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [jlgs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [jlgs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output jlgs_pkg::cfg_t              cfg
);

  localparam logic [63:0] ONE_FIX  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] TOL_FULL = ONE_FIX / 64'd100;
  localparam logic [63:0] INI_FULL = ONE_FIX * 64'd75;
  localparam logic [63:0] HUN_FULL = ONE_FIX * 64'd100;
  localparam logic [jlgs_pkg::VAL_W-1:0] TOL_RST = TOL_FULL[jlgs_pkg::VAL_W-1:0];
  localparam logic [jlgs_pkg::VAL_W-1:0] INI_RST = INI_FULL[jlgs_pkg::VAL_W-1:0];
  localparam logic [jlgs_pkg::VAL_W-1:0] HUN_RST = HUN_FULL[jlgs_pkg::VAL_W-1:0];

  jlgs_pkg::cfg_t     cfg_r;
  jlgs_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx        = jlgs_pkg::reg_idx_t'(cfg_paddr[jlgs_pkg::CFG_AW-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_size  <= jlgs_pkg::GRID_SIZE_RST;
      cfg_r.tolerance  <= TOL_RST;
      cfg_r.iter_limit <= jlgs_pkg::ITER_LIMIT_RST;
      cfg_r.init_value <= INI_RST;
      cfg_r.edge_top   <= HUN_RST;
      cfg_r.edge_bot   <= '0;
      cfg_r.edge_left  <= HUN_RST;
      cfg_r.edge_right <= HUN_RST;
    end else if (wr_en) begin
      unique case (idx)
        jlgs_pkg::REG_GRID_SIZE:  cfg_r.grid_size  <= cfg_pwdata[jlgs_pkg::GS_W-1:0];
        jlgs_pkg::REG_TOLERANCE:  cfg_r.tolerance  <= cfg_pwdata[jlgs_pkg::VAL_W-1:0];
        jlgs_pkg::REG_ITER_LIMIT: cfg_r.iter_limit <= cfg_pwdata[jlgs_pkg::SWEEP_W-1:0];
        jlgs_pkg::REG_INIT_VALUE: cfg_r.init_value <= cfg_pwdata[jlgs_pkg::VAL_W-1:0];
        jlgs_pkg::REG_EDGE_TOP:   cfg_r.edge_top   <= cfg_pwdata[jlgs_pkg::VAL_W-1:0];
        jlgs_pkg::REG_EDGE_BOT:   cfg_r.edge_bot   <= cfg_pwdata[jlgs_pkg::VAL_W-1:0];
        jlgs_pkg::REG_EDGE_LEFT:  cfg_r.edge_left  <= cfg_pwdata[jlgs_pkg::VAL_W-1:0];
        jlgs_pkg::REG_EDGE_RIGHT: cfg_r.edge_right <= cfg_pwdata[jlgs_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      jlgs_pkg::REG_GRID_SIZE:  cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.grid_size);
      jlgs_pkg::REG_TOLERANCE:  cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.tolerance);
      jlgs_pkg::REG_ITER_LIMIT: cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.iter_limit);
      jlgs_pkg::REG_INIT_VALUE: cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.init_value);
      jlgs_pkg::REG_EDGE_TOP:   cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.edge_top);
      jlgs_pkg::REG_EDGE_BOT:   cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.edge_bot);
      jlgs_pkg::REG_EDGE_LEFT:  cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.edge_left);
      jlgs_pkg::REG_EDGE_RIGHT: cfg_prdata = jlgs_pkg::CFG_DW'(cfg_r.edge_right);
      default:                  cfg_prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/jlgs_grid_mem.sv
// One grid buffer: synchronous memory, one write port, one read port,
// registered read data. Depends on nothing.
module jlgs_grid_mem #(
  parameter int AW = 12,
  parameter int DW = 23
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // hold the last read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/jlgs_sweep_engine.sv
// Solve sequencer: fills the current grid, then runs Jacobi sweeps from the
// current buffer into the other one. Depends on jlgs_pkg.
module jlgs_sweep_engine #(
  parameter int GRID_MAX = jlgs_pkg::GRID_MAX_DEF,
  localparam int CW = $clog2(GRID_MAX),
  localparam int AW = 2 * CW
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  jlgs_pkg::cfg_t             cfg,
  input  logic                       start,
  input  logic [CW-1:0]              size_m1,
  input  logic [jlgs_pkg::VAL_W-1:0] rdata_a,
  input  logic [jlgs_pkg::VAL_W-1:0] rdata_b,
  output jlgs_pkg::mem_ctl_t         mem_ctl,
  output logic [AW-1:0]              rd_addr,
  output logic [AW-1:0]              wr_addr,
  output logic [jlgs_pkg::VAL_W-1:0] wr_data,
  output logic                       cur_b,
  output jlgs_pkg::status_t          status
);

  localparam int VW = jlgs_pkg::VAL_W;
  localparam int SUM_W = VW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_RD_C,
    S_RD_U,
    S_RD_D,
    S_RD_R,
    S_CALC,
    S_CHECK
  } state_t;

  state_t                       state_r;
  logic [CW-1:0]                row_r, col_r, nm1_r;
  logic [jlgs_pkg::SWEEP_W-1:0] sweeps_r;
  logic                         conv_r, done_r, cur_b_r, drain_r;
  logic [VW-1:0]                maxd_r, diff_r, up_r, dn_r, ctr_r, lft_r;
  logic                         diff_vld_r;

  logic [VW-1:0]                src, nb_up, nb_dn, nb_lf, nb_rt, v_new, diff;
  logic [SUM_W-1:0]             sum;
  logic [CW-1:0]                row_up, row_dn, col_rt;
  logic                         last_col, last_row;
  logic [jlgs_pkg::SWEEP_W-1:0] sweeps_inc;
  logic [VW-1:0]                maxd_now;

  assign src      = cur_b_r ? rdata_b : rdata_a;
  assign last_col = (col_r == nm1_r);
  assign last_row = (row_r == nm1_r);
  assign row_up   = row_r - CW'(1);
  assign row_dn   = row_r + CW'(1);
  assign col_rt   = col_r + CW'(1);

  // five-point stencil of the cell at (row_r, col_r); right neighbor arrives now
  assign nb_up = (row_r == '0) ? cfg.edge_top  : up_r;
  assign nb_dn = last_row      ? cfg.edge_bot  : dn_r;
  assign nb_lf = (col_r == '0) ? cfg.edge_left : lft_r;
  assign nb_rt = last_col      ? cfg.edge_right : src;
  assign sum   = SUM_W'(nb_up) + SUM_W'(nb_dn) + SUM_W'(nb_lf) + SUM_W'(nb_rt);
  assign v_new = sum[SUM_W-1:2];
  assign diff  = (v_new >= ctr_r) ? v_new - ctr_r : ctr_r - v_new;

  assign sweeps_inc = sweeps_r + jlgs_pkg::SWEEP_W'(1);
  assign maxd_now   = (diff_vld_r && diff_r > maxd_r) ? diff_r : maxd_r;

  always_comb begin
    mem_ctl = '0;
    rd_addr = {row_r, col_r};
    wr_addr = {row_r, col_r};
    wr_data = v_new;
    unique case (state_r)
      S_FILL: begin
        mem_ctl.we_a = !cur_b_r;
        mem_ctl.we_b = cur_b_r;
        wr_data      = cfg.init_value;
      end
      S_RD_C: begin
        mem_ctl.rd_en = 1'b1;
      end
      S_RD_U: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = {row_up, col_r};
      end
      S_RD_D: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = {row_dn, col_r};
      end
      S_RD_R: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = {row_r, col_rt};
      end
      S_CALC: begin
        // write the new cell, and start the up read of the next cell
        mem_ctl.we_a  = cur_b_r;
        mem_ctl.we_b  = !cur_b_r;
        mem_ctl.rd_en = !last_col;
        rd_addr       = {row_up, col_rt};
      end
      S_IDLE, S_CHECK: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cur_b_r    <= 1'b0;
      done_r     <= 1'b0;
      conv_r     <= 1'b0;
      sweeps_r   <= '0;
      diff_vld_r <= 1'b0;
      drain_r    <= 1'b0;
    end else begin
      done_r     <= 1'b0;
      diff_vld_r <= 1'b0;
      maxd_r     <= maxd_now;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            nm1_r    <= size_m1;
            row_r    <= '0;
            col_r    <= '0;
            sweeps_r <= '0;
            conv_r   <= 1'b0;
            state_r  <= S_FILL;
          end
        end
        S_FILL: begin
          if (!last_col) begin
            col_r <= col_rt;
          end else if (!last_row) begin
            col_r <= '0;
            row_r <= row_dn;
          end else if (cfg.iter_limit == '0) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            row_r   <= '0;
            col_r   <= '0;
            maxd_r  <= '0;
            state_r <= S_RD_C;
          end
        end
        S_RD_C: begin
          state_r <= S_RD_U;
        end
        S_RD_U: begin
          ctr_r   <= src;
          state_r <= S_RD_D;
        end
        S_RD_D: begin
          up_r    <= src;
          state_r <= S_RD_R;
        end
        S_RD_R: begin
          dn_r    <= src;
          state_r <= S_CALC;
        end
        S_CALC: begin
          diff_r     <= diff;
          diff_vld_r <= 1'b1;
          lft_r      <= ctr_r;
          ctr_r      <= src;
          if (!last_col) begin
            col_r   <= col_rt;
            state_r <= S_RD_D;
          end else if (!last_row) begin
            col_r   <= '0;
            row_r   <= row_dn;
            state_r <= S_RD_C;
          end else begin
            drain_r <= 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          // with drain_r set, fold in the last cell's change; with it clear, decide
          drain_r <= 1'b0;
          if (!drain_r) begin
            cur_b_r  <= !cur_b_r;
            sweeps_r <= sweeps_inc;
            row_r    <= '0;
            col_r    <= '0;
            if (maxd_r <= cfg.tolerance) begin
              conv_r  <= 1'b1;
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else if (sweeps_inc == cfg.iter_limit) begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              maxd_r  <= '0;
              state_r <= S_RD_C;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cur_b         = cur_b_r;
  assign status.done   = done_r;
  assign status.conv   = conv_r;
  assign status.sweeps = sweeps_r;

endmodule

>>> hw/rtl/jacobi_laplace_grid_solver_top.sv
// Top level of the Jacobi Laplace grid solver: stream ports, config port,
// the two grid buffers and the result register. Depends on jlgs_pkg and
// jlgs_cfg_regs, jlgs_grid_mem, jlgs_sweep_engine.
//
//   port group  direction  handshake                  payload
//   in_*        request    in_tvalid / in_tready      in_tdata row,col; in_tuser action
//   out_*       result     out_tvalid / out_tready    out_tdata value,sweeps,converged
//   cfg_*       config     psel & penable & pwrite    cfg_paddr, cfg_pwdata
//
// Reads stream at one per cycle while out_tready does not stall the output; a
// result passes the grid buffer read register, then the output register.
// A solve request fills n*n cells, then runs sweeps whose pace is bounded
// by the single read port of the source buffer (three reads per cell, plus
// the center read at each row start). No request is taken while a solve runs.
// Reset is synchronous; grid buffers are not cleared, reads before the first
// solve return 0.
module jacobi_laplace_grid_solver_top #(
  parameter int GRID_MAX  = jlgs_pkg::GRID_MAX_DEF,
  parameter int FRAC_BITS = jlgs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [jlgs_pkg::IN_W-1:0]   in_tdata,   // [5:0] row, [11:6] col
  input  logic                        in_tuser,   // [0] action
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [jlgs_pkg::OUT_W-1:0]  out_tdata,  // [22:0] cell_value,
                                                  // [38:23] sweep_count, [39] converged
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [jlgs_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [jlgs_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [jlgs_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);

  localparam int CW = $clog2(GRID_MAX);
  localparam int AW = 2 * CW;
  localparam int NW = $clog2(GRID_MAX + 1);
  localparam int SW = (NW > jlgs_pkg::GS_W) ? NW : jlgs_pkg::GS_W;
  localparam int VW = jlgs_pkg::VAL_W;
  localparam int PW = jlgs_pkg::POS_W;

  jlgs_pkg::cfg_t     cfg;
  jlgs_pkg::mem_ctl_t mem_ctl;
  jlgs_pkg::status_t  status;

  logic [AW-1:0] eng_rd_addr, wr_addr, rd_addr;
  logic [VW-1:0] wr_data, rdata_a, rdata_b, rdata_cur;
  logic          cur_b, rd_en, start;

  logic [SW-1:0] gs_w, size_n, size_nm1, row_w, col_w;
  logic [PW-1:0] in_row, in_col;
  logic          in_acc, is_read, in_range;

  logic                         solve_act_r, grid_valid_r;
  logic                         pend_r, pend_hit_r, pend_move;
  logic                         out_valid_r, out_conv_r;
  logic [VW-1:0]                out_val_r;
  logic [jlgs_pkg::SWEEP_W-1:0] out_sw_r, last_sw_r;
  logic                         last_conv_r;

  jlgs_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // grid size in use, clamped to [2, GRID_MAX]
  assign gs_w     = SW'(cfg.grid_size);
  assign size_n   = (gs_w < SW'(2)) ? SW'(2) :
                    (gs_w > SW'(GRID_MAX)) ? SW'(GRID_MAX) : gs_w;
  assign size_nm1 = size_n - SW'(1);

  assign in_row   = in_tdata[PW-1:0];
  assign in_col   = in_tdata[2*PW-1:PW];
  assign row_w    = SW'(in_row);
  assign col_w    = SW'(in_col);
  assign in_range = (row_w < size_n) && (col_w < size_n);
  assign is_read  = (in_tuser == jlgs_pkg::ACT_READ);

  assign pend_move = pend_r && (!out_valid_r || out_tready);
  assign in_tready = !solve_act_r && (!pend_r || pend_move);
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && !is_read;

  jlgs_sweep_engine #(
    .GRID_MAX (GRID_MAX)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .start   (start),
    .size_m1 (size_nm1[CW-1:0]),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .mem_ctl (mem_ctl),
    .rd_addr (eng_rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .cur_b   (cur_b),
    .status  (status)
  );

  // the engine owns the read port while a solve runs
  assign rd_en   = solve_act_r ? mem_ctl.rd_en : (in_acc && is_read);
  assign rd_addr = solve_act_r ? eng_rd_addr : {row_w[CW-1:0], col_w[CW-1:0]};

  jlgs_grid_mem #(
    .AW (AW),
    .DW (VW)
  ) u_grid_a (
    .clk   (clk),
    .we    (mem_ctl.we_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata_a)
  );

  jlgs_grid_mem #(
    .AW (AW),
    .DW (VW)
  ) u_grid_b (
    .clk   (clk),
    .we    (mem_ctl.we_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata_b)
  );

  assign rdata_cur = cur_b ? rdata_b : rdata_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      solve_act_r  <= 1'b0;
      grid_valid_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      last_sw_r    <= '0;
      last_conv_r  <= 1'b0;
    end else begin
      if (pend_move) begin
        pend_r <= 1'b0;
      end
      if (in_acc) begin
        if (is_read) begin
          pend_r     <= 1'b1;
          pend_hit_r <= grid_valid_r && in_range;
        end else begin
          solve_act_r  <= 1'b1;
          grid_valid_r <= 1'b1;
        end
      end
      // a finished solve queues its result with a zero cell value
      if (status.done) begin
        solve_act_r <= 1'b0;
        last_sw_r   <= status.sweeps;
        last_conv_r <= status.conv;
        pend_r      <= 1'b1;
        pend_hit_r  <= 1'b0;
      end
      if (pend_move) begin
        out_valid_r <= 1'b1;
        out_val_r   <= pend_hit_r ? rdata_cur : '0;
        out_sw_r    <= last_sw_r;
        out_conv_r  <= last_conv_r;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_conv_r, out_sw_r, out_val_r};

endmodule

>>> verif/jacobi_laplace_grid_solver_top_test.sv
// Self-checking testbench for jacobi_laplace_grid_solver_top: directed and random
// solve and read requests, register writes over the config port, a behavioral
// grid predictor and a result scoreboard. Depends on jlgs_pkg and the top level.
`timescale 1ns / 100ps

module jacobi_laplace_grid_solver_top_test;
  import jlgs_pkg::*;

  localparam int          STRIDE      = GRID_MAX_DEF;
  localparam int          CELLS       = STRIDE * STRIDE;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          PHASES      = 8;
  localparam int          PHASE_REQS  = 50;
  localparam int unsigned VAL_TOP     = 6553600;  // 100.0

  typedef struct packed {
    logic               conv;
    logic [SWEEP_W-1:0] sweeps;
    logic [VAL_W-1:0]   cell_val;
  } result_t;

  typedef struct {
    bit                is_write;
    reg_idx_t          reg_sel;
    logic [CFG_DW-1:0] wdata;
    action_t           act;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    bit                fixed;
    result_t           want;
  } step_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;   // [5:0] row, [11:6] col
  logic               in_tuser;   // [0] action
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;  // [22:0] cell_value, [38:23] sweep_count, [39] converged
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [CFG_AW-1:0]  cfg_paddr;
  logic [CFG_DW-1:0]  cfg_pwdata;
  logic [CFG_DW-1:0]  cfg_prdata;
  logic               cfg_pready;

  // Predictor state: two grid planes, which cells have been written, config shadow.
  logic [VAL_W-1:0]   plane [2][CELLS];
  bit                 plane_set [2][CELLS];
  int                 cur_plane;
  bit                 have_grid;
  logic [SWEEP_W-1:0] last_sweeps_q;
  bit                 last_conv_q;
  cfg_t               shadow;

  result_t     pending_results[$];
  step_t       plan[$];
  result_t     seen_res;
  result_t     want_res;
  bit          gapless;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned solves_sent;
  int unsigned reads_sent;
  int unsigned writes_done;

  jacobi_laplace_grid_solver_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int active_size();
    if (shadow.grid_size < 2) return 2;
    if (shadow.grid_size > STRIDE) return STRIDE;
    return int'(shadow.grid_size);
  endfunction

  // One Jacobi pass from the current plane into the other; returns the largest change.
  function automatic logic [VAL_W-1:0] sweep_once(int n);
    logic [VAL_W-1:0] up, down, lt, rt;
    logic [VAL_W+1:0] total;
    logic [VAL_W-1:0] nv, ov, dv, worst;
    int k, src, dst;
    src   = cur_plane;
    dst   = 1 - cur_plane;
    worst = '0;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        k = r * STRIDE + c;
        if (r == 0) up = shadow.edge_top; else up = plane[src][k-STRIDE];
        if (r == n - 1) down = shadow.edge_bot; else down = plane[src][k+STRIDE];
        if (c == 0) lt = shadow.edge_left; else lt = plane[src][k-1];
        if (c == n - 1) rt = shadow.edge_right; else rt = plane[src][k+1];
        total = {2'b00, up} + {2'b00, down} + {2'b00, lt} + {2'b00, rt};
        nv    = total[VAL_W+1:2];
        ov    = plane[src][k];
        dv    = (nv > ov) ? nv - ov : ov - nv;
        plane[dst][k]     = nv;
        plane_set[dst][k] = 1'b1;
        if (dv > worst) worst = dv;
      end
    end
    return worst;
  endfunction

  function automatic result_t predict_request(action_t act, logic [POS_W-1:0] r,
                                              logic [POS_W-1:0] c);
    result_t res;
    int n, sweeps;
    bit conv;
    n   = active_size();
    res = '0;
    if (act == ACT_SOLVE) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          plane[cur_plane][i*STRIDE+j]     = shadow.init_value;
          plane_set[cur_plane][i*STRIDE+j] = 1'b1;
        end
      end
      have_grid = 1'b1;
      sweeps    = 0;
      conv      = 1'b0;
      while (sweeps < int'(shadow.iter_limit)) begin
        logic [VAL_W-1:0] worst;
        worst     = sweep_once(n);
        cur_plane = 1 - cur_plane;
        sweeps++;
        if (worst <= shadow.tolerance) begin
          conv = 1'b1;
          break;
        end
      end
      last_sweeps_q = SWEEP_W'(sweeps);
      last_conv_q   = conv;
    end else if (have_grid && r < n && c < n) begin
      res.cell_val = plane[cur_plane][int'(r)*STRIDE+int'(c)];
    end
    res.sweeps = last_sweeps_q;
    res.conv   = last_conv_q;
    return res;
  endfunction

  function automatic void shadow_write(reg_idx_t sel, logic [CFG_DW-1:0] v);
    case (sel)
      REG_GRID_SIZE:  shadow.grid_size   = v[GS_W-1:0];
      REG_TOLERANCE:  shadow.tolerance   = v[VAL_W-1:0];
      REG_ITER_LIMIT: shadow.iter_limit  = v[SWEEP_W-1:0];
      REG_INIT_VALUE: shadow.init_value  = v[VAL_W-1:0];
      REG_EDGE_TOP:   shadow.edge_top    = v[VAL_W-1:0];
      REG_EDGE_BOT:   shadow.edge_bot    = v[VAL_W-1:0];
      REG_EDGE_LEFT:  shadow.edge_left   = v[VAL_W-1:0];
      REG_EDGE_RIGHT: shadow.edge_right  = v[VAL_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic step_t blank_step();
    step_t s;
    s.is_write = 1'b0;
    s.reg_sel  = REG_GRID_SIZE;
    s.wdata    = '0;
    s.act      = ACT_SOLVE;
    s.row      = '0;
    s.col      = '0;
    s.fixed    = 1'b0;
    s.want     = '0;
    return s;
  endfunction

  function automatic step_t reg_step(reg_idx_t sel, int unsigned v);
    step_t s;
    s          = blank_step();
    s.is_write = 1'b1;
    s.reg_sel  = sel;
    s.wdata    = v;
    return s;
  endfunction

  function automatic step_t req_step(action_t act, int r, int c);
    step_t s;
    s     = blank_step();
    s.act = act;
    s.row = POS_W'(r);
    s.col = POS_W'(c);
    return s;
  endfunction

  function automatic step_t req_known(action_t act, int r, int c, int unsigned v,
                                      int unsigned sw, bit cv);
    step_t s;
    s               = req_step(act, r, c);
    s.fixed         = 1'b1;
    s.want.cell_val = VAL_W'(v);
    s.want.sweeps   = SWEEP_W'(sw);
    s.want.conv     = cv;
    return s;
  endfunction

  // Hold the request until accepted, then queue its expected result.
  task automatic send_request(action_t act, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                              bit fixed, result_t want);
    result_t got;
    @(negedge clk);
    while (!gapless && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_W'({c, r});
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    got = predict_request(act, r, c);
    pending_results.push_back(fixed ? want : got);
    if (act == ACT_SOLVE) solves_sent++; else reads_sent++;
  endtask

  // Drain all outstanding results before touching a register.
  task automatic write_reg(reg_idx_t sel, logic [CFG_DW-1:0] v);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_AW'(4 * int'(sel));
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    shadow_write(sel, v);
    writes_done++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_tready <= gapless || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_res = result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: %h", out_tdata);
        fail_count++;
      end else begin
        want_res = pending_results.pop_front();
        results_seen++;
        if (seen_res.cell_val !== want_res.cell_val) begin
          $error("cell_value: expected %0d, got %0d", want_res.cell_val,
                 seen_res.cell_val);
          fail_count++;
        end
        if (seen_res.sweeps !== want_res.sweeps) begin
          $error("sweep_count: expected %0d, got %0d", want_res.sweeps, seen_res.sweeps);
          fail_count++;
        end
        if (seen_res.conv !== want_res.conv) begin
          $error("converged: expected %0d, got %0d", want_res.conv, seen_res.conv);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int pick, n, gs, lim;
    logic [POS_W-1:0] r, c;
    logic [CFG_DW-1:0] tol;

    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    gapless      = 1'b0;
    cycle_count  = 0;
    fail_count   = 0;
    results_seen = 0;
    solves_sent  = 0;
    reads_sent   = 0;
    writes_done  = 0;

    shadow.grid_size   = GRID_SIZE_RST;
    shadow.tolerance   = 23'd655;
    shadow.iter_limit  = ITER_LIMIT_RST;
    shadow.init_value  = 23'd4915200;
    shadow.edge_top    = VAL_W'(VAL_TOP);
    shadow.edge_bot    = '0;
    shadow.edge_left   = VAL_W'(VAL_TOP);
    shadow.edge_right  = VAL_W'(VAL_TOP);
    cur_plane     = 0;
    have_grid     = 1'b0;
    last_sweeps_q = '0;
    last_conv_q   = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reads ahead of any solve return zero.
    plan.push_back(req_known(ACT_READ, 0, 0, 0, 0, 0));
    plan.push_back(req_known(ACT_READ, 63, 63, 0, 0, 0));
    // Zero sweep limit: grid is only filled.
    plan.push_back(reg_step(REG_GRID_SIZE, 2));
    plan.push_back(reg_step(REG_ITER_LIMIT, 0));
    plan.push_back(reg_step(REG_INIT_VALUE, VAL_TOP));
    plan.push_back(reg_step(REG_TOLERANCE, 0));
    plan.push_back(req_known(ACT_SOLVE, 0, 0, 0, 0, 0));
    plan.push_back(req_known(ACT_READ, 1, 1, VAL_TOP, 0, 0));
    plan.push_back(req_known(ACT_READ, 2, 0, 0, 0, 0));
    plan.push_back(req_known(ACT_READ, 0, 2, 0, 0, 0));
    // Tolerance at 100.0: the first sweep always converges.
    plan.push_back(reg_step(REG_ITER_LIMIT, 65535));
    plan.push_back(reg_step(REG_TOLERANCE, VAL_TOP));
    plan.push_back(reg_step(REG_INIT_VALUE, 0));
    plan.push_back(req_known(ACT_SOLVE, 5, 9, 0, 1, 1));
    plan.push_back(req_step(ACT_READ, 0, 0));
    plan.push_back(req_step(ACT_READ, 1, 1));
    // Size below the minimum, tight tolerance, skewed edges.
    plan.push_back(reg_step(REG_GRID_SIZE, 0));
    plan.push_back(reg_step(REG_TOLERANCE, 0));
    plan.push_back(reg_step(REG_ITER_LIMIT, 30));
    plan.push_back(reg_step(REG_INIT_VALUE, VAL_TOP));
    plan.push_back(reg_step(REG_EDGE_TOP, 0));
    plan.push_back(reg_step(REG_EDGE_BOT, VAL_TOP));
    plan.push_back(reg_step(REG_EDGE_LEFT, 0));
    plan.push_back(reg_step(REG_EDGE_RIGHT, 0));
    plan.push_back(req_step(ACT_SOLVE, 63, 63));
    plan.push_back(req_step(ACT_READ, 1, 0));
    plan.push_back(req_step(ACT_READ, 0, 1));
    // Full grid, all edges at 100.0.
    plan.push_back(reg_step(REG_GRID_SIZE, 64));
    plan.push_back(reg_step(REG_ITER_LIMIT, 2));
    plan.push_back(reg_step(REG_INIT_VALUE, 0));
    plan.push_back(reg_step(REG_EDGE_TOP, VAL_TOP));
    plan.push_back(reg_step(REG_EDGE_LEFT, VAL_TOP));
    plan.push_back(reg_step(REG_EDGE_RIGHT, VAL_TOP));
    plan.push_back(req_step(ACT_SOLVE, 0, 0));
    plan.push_back(req_step(ACT_READ, 63, 63));
    plan.push_back(req_step(ACT_READ, 32, 17));
    plan.push_back(req_step(ACT_READ, 0, 63));
    // Size above the maximum clamps to the full grid.
    plan.push_back(reg_step(REG_GRID_SIZE, 127));
    plan.push_back(reg_step(REG_ITER_LIMIT, 1));
    plan.push_back(reg_step(REG_TOLERANCE, VAL_TOP));
    plan.push_back(req_step(ACT_SOLVE, 0, 0));
    plan.push_back(req_step(ACT_READ, 63, 0));
    plan.push_back(reg_step(REG_GRID_SIZE, 1));
    plan.push_back(reg_step(REG_ITER_LIMIT, 5));
    plan.push_back(reg_step(REG_TOLERANCE, 0));
    plan.push_back(reg_step(REG_EDGE_TOP, 0));
    plan.push_back(reg_step(REG_EDGE_BOT, 0));
    plan.push_back(reg_step(REG_EDGE_LEFT, 0));
    plan.push_back(reg_step(REG_EDGE_RIGHT, 0));
    plan.push_back(req_step(ACT_SOLVE, 0, 0));
    plan.push_back(req_step(ACT_READ, 1, 1));
    plan.push_back(req_step(ACT_READ, 63, 0));
    plan.push_back(reg_step(REG_GRID_SIZE, 3));
    plan.push_back(reg_step(REG_ITER_LIMIT, 0));
    plan.push_back(req_known(ACT_SOLVE, 0, 0, 0, 0, 0));
    plan.push_back(req_known(ACT_READ, 2, 2, 0, 0, 0));
    plan.push_back(req_step(ACT_READ, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].is_write)
        write_reg(plan[i].reg_sel, plan[i].wdata);
      else
        send_request(plan[i].act, plan[i].row, plan[i].col, plan[i].fixed, plan[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      pick = $urandom_range(99);
      if (pick < 10) gs = $urandom_range(1, 0);
      else if (pick < 20) gs = $urandom_range(16, 9);
      else gs = $urandom_range(8, 2);
      // Keep larger grids to a handful of sweeps.
      lim = (gs > 8) ? $urandom_range(4) : $urandom_range(24);
      case ($urandom_range(2))
        0:       tol = '0;
        1:       tol = $urandom_range(2000);
        default: tol = $urandom_range(VAL_TOP);
      endcase
      write_reg(REG_GRID_SIZE, gs);
      write_reg(REG_TOLERANCE, tol);
      write_reg(REG_ITER_LIMIT, lim);
      write_reg(REG_INIT_VALUE, $urandom_range(VAL_TOP));
      write_reg(REG_EDGE_TOP, $urandom_range(VAL_TOP));
      write_reg(REG_EDGE_BOT, $urandom_range(VAL_TOP));
      write_reg(REG_EDGE_LEFT, $urandom_range(VAL_TOP));
      write_reg(REG_EDGE_RIGHT, $urandom_range(VAL_TOP));
      gapless = (ph == 3);

      for (int i = 0; i < PHASE_REQS; i++) begin
        pick = $urandom_range(99);
        if ((i == 0 && $urandom_range(3) != 0) || pick < 12) begin
          r = POS_W'($urandom_range(63));
          c = POS_W'($urandom_range(63));
          send_request(ACT_SOLVE, r, c, 1'b0, '0);
        end else begin
          n = active_size();
          if (pick < 80) begin
            r = POS_W'($urandom_range(n - 1));
            c = POS_W'($urandom_range(n - 1));
          end else begin
            r = POS_W'($urandom_range(63));
            c = POS_W'($urandom_range(63));
          end
          // Steer away from cells no solve has ever written.
          if (have_grid && r < n && c < n && !plane_set[cur_plane][int'(r)*STRIDE+int'(c)]) begin
            r = '0;
            c = '0;
          end
          send_request(ACT_READ, r, c, 1'b0, '0);
        end
      end
    end
    gapless = 1'b0;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d solve and %0d read requests around %0d register writes;",
             solves_sent, reads_sent, writes_done);
    $display("checked %0d results in %0d cycles, %0d mismatches.",
             results_seen, cycle_count, fail_count);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/jlgs_pkg.sv
hw/rtl/jlgs_cfg_regs.sv
hw/rtl/jlgs_grid_mem.sv
hw/rtl/jlgs_sweep_engine.sv
hw/rtl/jacobi_laplace_grid_solver_top.sv
verif/jacobi_laplace_grid_solver_top_test.sv
